@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/tga_dec_pkg.sv @@
`timescale 1ns / 1ps

package tga_dec_pkg;

    localparam int TOTAL_W   = 30;
    localparam int ADDR_W    = 4;
    localparam int APB_DW    = 32;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_RLE    = 2'd1;
    localparam logic [1:0] REG_TOTAL  = 2'd2;

    // Pixel formats.
    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_RGB555 = 2'd1;
    localparam logic [1:0] FMT_BGR24  = 2'd2;
    localparam logic [1:0] FMT_BGRA32 = 2'd3;

    localparam logic [1:0]         RST_FORMAT = FMT_BGRA32;
    localparam logic               RST_RLE    = 1'b0;
    localparam logic [TOTAL_W-1:0] RST_TOTAL  = 30'd1;

    // Packet header: bit 7 marks a repeat packet, low seven bits hold length - 1.
    localparam int         HDR_REPEAT_BIT = 7;
    localparam logic [6:0] HDR_LEN_MASK   = 7'h7F;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

    typedef logic [31:0]        t_argb;
    typedef logic [TOTAL_W-1:0] t_total;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic       run_length_mode;
        t_total     pixel_total;
    } t_cfg;

    typedef struct packed {
        t_argb        pixel_argb;
        logic [7:0]   repeat_count;
        t_total       first_index;
        logic         last_of_image;
        logic         overflow_error;
    } t_run;

    function automatic t_argb make_pixel(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [1:0] fmt);
        logic [15:0] w;
        t_argb       px;
        w = {b1, b0};
        unique case (fmt)
            FMT_GRAY8:  px = {b0, b0, b0, b0};
            FMT_RGB555: px = {ALPHA_OPAQUE, w[14:10], 3'b000, w[9:5], 3'b000,
                              w[4:0], 3'b000};
            FMT_BGR24:  px = {ALPHA_OPAQUE, b2, b1, b0};
            default:    px = {b3, b2, b1, b0};
        endcase
        return px;
    endfunction

endpackage

@@ hw/rtl/tga_dec_ifs.sv @@
`timescale 1ns / 1ps

// Byte channel into the decoder.
interface tga_dec_byte_if
    import tga_dec_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Pixel run channel out of the decoder.
interface tga_dec_run_if
    import tga_dec_pkg::*;
();
    logic       valid;
    logic       ready;
    t_argb      pixel_argb;
    logic [7:0] repeat_count;
    t_total     first_index;
    logic       last_of_image;
    logic       overflow_error;

    modport source (output valid, output pixel_argb, output repeat_count,
                    output first_index, output last_of_image, output overflow_error,
                    input ready);
    modport sink   (input valid, input pixel_argb, input repeat_count,
                    input first_index, input last_of_image, input overflow_error,
                    output ready);
endinterface

@@ hw/rtl/tga_dec_cfg.sv @@
`timescale 1ns / 1ps

module tga_dec_cfg
    import tga_dec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format    <= RST_FORMAT;
            r_cfg.run_length_mode <= RST_RLE;
            r_cfg.pixel_total     <= RST_TOTAL;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FORMAT: r_cfg.pixel_format    <= pwdata[1:0];
                REG_RLE:    r_cfg.run_length_mode <= pwdata[0];
                REG_TOTAL:  r_cfg.pixel_total     <= pwdata[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FORMAT: prdata = APB_DW'(r_cfg.pixel_format);
            REG_RLE:    prdata = APB_DW'(r_cfg.run_length_mode);
            REG_TOTAL:  prdata = APB_DW'(r_cfg.pixel_total);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/tga_dec_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_dec_core
    import tga_dec_pkg::*;
#(
    parameter int INDEX_WIDTH = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    output t_run       o_run
);

    // Width that holds both the pixel counter and the pixel total.
    localparam int CW = (INDEX_WIDTH > TOTAL_W) ? INDEX_WIDTH : TOTAL_W;

    logic [1:0]             r_phase,     n_phase,     e_phase;
    logic [23:0]            r_collector, n_collector, e_collector;
    logic                   r_expect,    n_expect,    e_expect;
    logic                   r_repeat,    n_repeat,    e_repeat;
    logic [7:0]             r_remaining, n_remaining, e_remaining;
    logic [INDEX_WIDTH-1:0] r_done,      n_done,      e_done;
    logic                   r_halted,    n_halted,    e_halted;

    logic [7:0]    bytes [4];
    logic [CW-1:0] done_w;
    logic [CW-1:0] total_w;
    logic [CW-1:0] avail;
    logic [7:0]    pkt_len;
    logic [7:0]    count;
    logic          ovf;
    logic          ignore;

    always_comb begin
        // A frame start clears the frame state before this byte is used.
        e_phase     = i_frame_start ? 2'd0  : r_phase;
        e_collector = i_frame_start ? 24'd0 : r_collector;
        e_expect    = i_frame_start ? 1'b1  : r_expect;
        e_repeat    = i_frame_start ? 1'b0  : r_repeat;
        e_remaining = i_frame_start ? 8'd0  : r_remaining;
        e_done      = i_frame_start ? '0    : r_done;
        e_halted    = i_frame_start ? 1'b0  : r_halted;

        done_w  = CW'(e_done);
        total_w = CW'(i_cfg.pixel_total);
        avail   = total_w - done_w;
        pkt_len = (e_remaining == 8'd0) ? 8'd1 : e_remaining;

        ignore = (i_cfg.run_length_mode && (i_cfg.pixel_format == FMT_GRAY8 ||
                  i_cfg.pixel_format == FMT_RGB555)) || e_halted || (done_w >= total_w);

        bytes[0] = e_collector[7:0];
        bytes[1] = e_collector[15:8];
        bytes[2] = e_collector[23:16];
        bytes[3] = 8'd0;
        bytes[e_phase] = i_data_byte;

        n_phase     = r_phase;
        n_collector = r_collector;
        n_expect    = r_expect;
        n_repeat    = r_repeat;
        n_remaining = r_remaining;
        n_done      = r_done;
        n_halted    = r_halted;
        count       = 8'd1;
        ovf         = 1'b0;
        o_valid     = 1'b0;

        o_run.pixel_argb     = make_pixel(bytes[0], bytes[1], bytes[2], bytes[3],
                                          i_cfg.pixel_format);
        o_run.first_index    = done_w[TOTAL_W-1:0];
        o_run.repeat_count   = count;
        o_run.last_of_image  = 1'b0;
        o_run.overflow_error = 1'b0;

        if (i_fire) begin
            n_phase     = e_phase;
            n_collector = e_collector;
            n_expect    = e_expect;
            n_repeat    = e_repeat;
            n_remaining = e_remaining;
            n_done      = e_done;
            n_halted    = e_halted;

            if (!ignore) begin
                if (i_cfg.run_length_mode && e_expect) begin
                    n_repeat    = i_data_byte[HDR_REPEAT_BIT];
                    n_remaining = {1'b0, i_data_byte[6:0] & HDR_LEN_MASK} + 8'd1;
                    n_expect    = 1'b0;
                    n_phase     = 2'd0;
                    n_collector = 24'd0;
                end else if (e_phase < i_cfg.pixel_format) begin
                    // Still gathering bytes of this pixel.
                    case (e_phase)
                        2'd0:    n_collector[7:0]   = i_data_byte;
                        2'd1:    n_collector[15:8]  = i_data_byte;
                        2'd2:    n_collector[23:16] = i_data_byte;
                        default: ;
                    endcase
                    n_phase = e_phase + 2'd1;
                end else begin
                    n_phase     = 2'd0;
                    n_collector = 24'd0;
                    if (i_cfg.run_length_mode) begin
                        if (e_repeat) begin
                            count       = pkt_len;
                            n_remaining = 8'd0;
                            n_expect    = 1'b1;
                            if (CW'(pkt_len) > avail) begin
                                count = avail[7:0];
                                ovf   = 1'b1;
                            end
                        end else begin
                            n_remaining = pkt_len - 8'd1;
                            if (n_remaining == 8'd0) begin
                                n_expect = 1'b1;
                            end else if (avail == CW'(1)) begin
                                ovf = 1'b1;
                            end
                        end
                    end
                    n_done  = e_done + INDEX_WIDTH'(count);
                    o_valid = 1'b1;
                    o_run.repeat_count   = count;
                    o_run.overflow_error = ovf;
                    o_run.last_of_image  = (CW'(n_done) >= total_w);
                    if (o_run.last_of_image) begin
                        n_halted = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_collector <= 24'd0;
            r_expect    <= 1'b1;
            r_repeat    <= 1'b0;
            r_remaining <= 8'd0;
            r_done      <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_collector <= n_collector;
            r_expect    <= n_expect;
            r_repeat    <= n_repeat;
            r_remaining <= n_remaining;
            r_done      <= n_done;
            r_halted    <= n_halted;
        end
    end

    `ASSERT_NEVER(a_zero_run, i_clk, i_rst_n, o_valid && (o_run.repeat_count == 8'd0), "empty run produced")
    `ASSERT_PROP(a_ovf_is_last, i_clk, i_rst_n, (o_valid && o_run.overflow_error) |-> o_run.last_of_image, "overflow without last")
    `ASSERT_PROP(a_last_halts, i_clk, i_rst_n, (o_valid && o_run.last_of_image) |=> r_halted, "last run did not halt")
    `ASSERT_NEVER(a_halted_quiet, i_clk, i_rst_n, r_halted && !i_frame_start && o_valid, "run while halted")

endmodule

@@ hw/rtl/tga_pixel_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// Path: an accepted byte enters the input register; the run it completes is held in the result
// register until taken; bytes that complete no pixel produce no transfer.
// Throughput: one byte per cycle; the single-pass decode and the result register allow a
// new byte every cycle while the output side keeps taking runs.
// Reset: synchronous, active low; clears handshake state, frame state and restores the
// configuration registers (format 3, plain mode, pixel total 1).

module tga_pixel_stream_decoder_top
    import tga_dec_pkg::*;
#(
    parameter int INDEX_WIDTH = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tga_dec_byte_if.sink      i_byte,
    tga_dec_run_if.source     o_run,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration registers, reached over the register port.
    t_cfg cfg;

    tga_dec_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: holds one accepted byte until the decode stage takes it.
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_fs;

    // Result register: holds one finished run until the downstream transfer.
    logic r_out_valid;
    t_run r_out;

    // The decode stage moves whenever the result register is free or being emptied.
    // A byte in the input register is decoded at that edge and the frame state updated.
    logic advance;
    logic fire;
    logic core_valid;
    t_run core_run;

    assign advance      = !r_out_valid || o_run.ready;
    assign fire         = r_in_valid && advance;
    assign i_byte.ready = !r_in_valid || advance;

    tga_dec_core #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_data_byte   (r_in_data),
        .i_frame_start (r_in_fs),
        .i_cfg         (cfg),
        .o_valid       (core_valid),
        .o_run         (core_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (advance) begin
                r_out_valid <= fire && core_valid;
            end
        end
    end

    // Payload registers carry no reset; the valid flags above qualify them.
    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_data <= i_byte.data_byte;
            r_in_fs   <= i_byte.frame_start;
        end
        if (fire && core_valid) begin
            r_out <= core_run;
        end
    end

    assign o_run.valid          = r_out_valid;
    assign o_run.pixel_argb     = r_out.pixel_argb;
    assign o_run.repeat_count   = r_out.repeat_count;
    assign o_run.first_index    = r_out.first_index;
    assign o_run.last_of_image  = r_out.last_of_image;
    assign o_run.overflow_error = r_out.overflow_error;

endmodule
